// File: rtl/cartridge_real_time_clock_defines.svh
// Assertion macros for the cartridge real-time clock.
// Needs clk and arst_n in the scope of use.
`ifndef CARTRIDGE_REAL_TIME_CLOCK_DEFINES_SVH
`define CARTRIDGE_REAL_TIME_CLOCK_DEFINES_SVH

// same-cycle property
`define CRTC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition now, consequence in the next cycle
`define CRTC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/crtc_pkg.sv
// Shared types, codes and constants for the cartridge real-time clock.
// No dependencies.
`default_nettype none
package crtc_pkg;

	localparam int unsigned PERIOD_W     = 24;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd4213440;
	localparam logic [5:0] SEC_LIMIT    = 6'd60;
	localparam logic [5:0] MIN_LIMIT    = 6'd60;
	localparam logic [4:0] HOUR_LIMIT   = 5'd24;
	localparam logic [8:0] DAY_MAX      = 9'd511;
	localparam logic [7:0] DAY_HI_MASK  = 8'hC1;
	localparam logic [7:0] UNMAPPED     = 8'hFF;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LATCH = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} crtc_op_t;

	typedef enum logic [2:0] {
		SEL_SEC    = 3'd0,
		SEL_MIN    = 3'd1,
		SEL_HOUR   = 3'd2,
		SEL_DAY_LO = 3'd3,
		SEL_DAY_HI = 3'd4
	} crtc_sel_t;

	typedef struct packed {
		logic       day_ovf;
		logic       halted;
		logic [8:0] days;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} crtc_time_t;

	typedef struct packed {
		logic       step;   // advance one second
		logic       wr;
		crtc_sel_t  sel;
		logic [7:0] data;
	} crtc_cmd_t;

	// register file image: sec, min, hour, day low, day high from the low byte up
	function automatic logic [39:0] crtc_pack(input crtc_time_t t);
		crtc_pack = {t.day_ovf, t.halted, 5'b0, t.days[8], t.days[7:0],
			3'b0, t.hours, 2'b0, t.minutes, 2'b0, t.seconds};
	endfunction

endpackage
`default_nettype wire

// File: rtl/crtc_time.sv
// Live time counters: second/minute/hour/day cascade, halt and overflow carry.
// Depends on crtc_pkg.
`default_nettype none
module crtc_time (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire crtc_pkg::crtc_cmd_t  cmd,
	output crtc_pkg::crtc_time_t   live
);
	import crtc_pkg::*;

	crtc_time_t time_q;
	crtc_time_t time_d;

	logic [5:0] sec_inc, min_inc;
	logic [4:0] hour_inc;
	logic       sec_c, min_c, hour_c;
	logic [7:0] wmask;

	assign live = time_q;

	always_comb begin
		sec_inc  = time_q.seconds + 6'd1;
		min_inc  = time_q.minutes + 6'd1;
		hour_inc = time_q.hours + 5'd1;
		sec_c    = (sec_inc == SEC_LIMIT);
		min_c    = sec_c && (min_inc == MIN_LIMIT);
		hour_c   = min_c && (hour_inc == HOUR_LIMIT);
		wmask    = cmd.data & DAY_HI_MASK;
		time_d   = time_q;
		if (cmd.step) begin
			time_d.seconds = sec_c ? 6'd0 : sec_inc;
			if (sec_c)
				time_d.minutes = min_c ? 6'd0 : min_inc;
			if (min_c)
				time_d.hours = hour_c ? 5'd0 : hour_inc;
			if (hour_c) begin
				if (time_q.days == DAY_MAX) begin
					time_d.days    = 9'd0;
					time_d.day_ovf = 1'b1;
				end else begin
					time_d.days = time_q.days + 9'd1;
				end
			end
		end
		if (cmd.wr) begin
			case (cmd.sel)
				SEL_SEC:    time_d.seconds = cmd.data[5:0];
				SEL_MIN:    time_d.minutes = cmd.data[5:0];
				SEL_HOUR:   time_d.hours = cmd.data[4:0];
				SEL_DAY_LO: time_d.days = {time_q.days[8], cmd.data};
				SEL_DAY_HI: begin
					time_d.days    = {wmask[0], time_q.days[7:0]};
					time_d.halted  = wmask[6];
					time_d.day_ovf = wmask[7];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			time_q <= '0;
		else
			time_q <= time_d;
	end

endmodule
`default_nettype wire

// File: rtl/cartridge_real_time_clock.sv
// An accepted item sits in the input register, then its result is registered in out_valid/read_data.
// Throughput: one item per cycle unless out_ready stalls; input and result register form a two-entry pipe.
// Reset (arst_n, asynchronous): counters, latch and halt clear, tick period and prescaler
// load 4213440, both pipe stages empty. Config port always ready.
// Depends on crtc_pkg, crtc_time and cartridge_real_time_clock_defines.svh.
`default_nettype none
module cartridge_real_time_clock (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [2:0]  reg_select,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       read_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [23:0] tick_period
);
	import crtc_pkg::*;
	`include "cartridge_real_time_clock_defines.svh"

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] prescale_q;
	logic [PERIOD_W-1:0] prescale_base;
	logic                valid_s1;
	crtc_op_t            op_s1;
	crtc_sel_t           sel_s1;
	logic [7:0]          data_s1;
	logic                out_valid_q;
	logic [7:0]          read_data_q;
	logic [39:0]         latched_q;
	logic                advance;
	logic                is_tick;
	logic [7:0]          result;
	crtc_cmd_t           cmd;
	crtc_time_t          live;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign is_tick   = advance && (op_s1 == OP_TICK);

	always_comb begin
		prescale_base = (prescale_q == '0) ? period_q : prescale_q;
		cmd.step = is_tick && (prescale_q == '0) && !live.halted;
		cmd.wr   = advance && (op_s1 == OP_WRITE);
		cmd.sel  = sel_s1;
		cmd.data = data_s1;
		result   = UNMAPPED;
		if (op_s1 == OP_READ) begin
			case (sel_s1)
				SEL_SEC:    result = latched_q[7:0];
				SEL_MIN:    result = latched_q[15:8];
				SEL_HOUR:   result = latched_q[23:16];
				SEL_DAY_LO: result = latched_q[31:24];
				SEL_DAY_HI: result = latched_q[39:32];
				default:    result = UNMAPPED;
			endcase
		end
	end

	crtc_time u_time (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.live   (live)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			prescale_q  <= PERIOD_RESET;
			latched_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				period_q <= tick_period;
			if (is_tick)
				prescale_q <= prescale_base - 24'd1;
			if (advance && (op_s1 == OP_LATCH))
				latched_q <= crtc_pack(live);
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= crtc_op_t'(opcode);
			sel_s1  <= crtc_sel_t'(reg_select);
			data_s1 <= write_data;
		end
		if (advance)
			read_data_q <= result;
	end

	`CRTC_ASSERT(a_stall_only_when_full, in_ready || (valid_s1 && out_valid_q && !out_ready), "input stalled with room in the pipe")
	`CRTC_ASSERT_NEXT(a_non_read_ff, advance && (op_s1 != OP_READ), read_data_q == UNMAPPED, "non-read item gave a byte other than 0xFF")
	`CRTC_ASSERT_NEXT(a_reload, is_tick && (prescale_q == '0), prescale_q == $past(period_q) - 24'd1, "prescaler did not reload from the tick period")
	`CRTC_ASSERT_NEXT(a_ovf_sticky, live.day_ovf && !(cmd.wr && (cmd.sel == SEL_DAY_HI)), live.day_ovf, "day overflow cleared without a day-high write")

endmodule
`default_nettype wire
